[rtl/ssp_pkg.sv]
// Shared types and constants for the smooth scroll position engine.
// Holds field widths, command codes, lane operations and parameter defaults.
// No dependencies.
package ssp_pkg;

  localparam int PosW  = 24;
  localparam int MaxW  = 23;
  localparam int TimeW = 16;
  localparam int EaseW = 17;
  localparam int SqW   = 49;

  localparam int SnapDistanceDef = 128;
  localparam int RubberBandDef   = 77;
  localparam int EaseWindowDef   = 300;

  typedef enum logic [2:0] {
    FN_SET_POS   = 3'd0,
    FN_SCROLL_TO = 3'd1,
    FN_SCROLL_BY = 3'd2,
    FN_TICK      = 3'd3,
    FN_STOP      = 3'd4
  } func_t;

  localparam logic [1:0] CFG_MAX_H = 2'd0;
  localparam logic [1:0] CFG_MAX_V = 2'd1;
  localparam logic [1:0] CFG_OVS   = 2'd2;

  typedef enum logic [3:0] {
    LOP_NONE,
    LOP_LOAD_ARG,
    LOP_LOAD_SUM,
    LOP_CLAMP_GOAL,
    LOP_PLACE,
    LOP_STOP,
    LOP_DIFF,
    LOP_SQUARE,
    LOP_SNAP,
    LOP_PROD,
    LOP_ADVANCE
  } lane_op_t;

  typedef struct packed {
    lane_op_t op;
    logic     ovs_en;
  } lane_ctl_t;

endpackage

[rtl/smooth_scroll_position_engine_core.sv]
// Smooth scroll position engine top level: command sequencer, snap merge and config.
// Instantiates two ssp_lane axis lanes and one ssp_ease unit. Depends on ssp_pkg.
//
// Usage: one command beat on the in_ channel (func, arg_x, arg_y, time_ms)
// gives exactly one result beat on the out_ channel (position, velocity,
// animating, notify). A beat moves when valid is high and stall is low.
// Commands are taken one at a time: in_stall is high while a command is at
// work. Set position and scroll by step through load and place, scroll to
// through load, clamp and, if time is zero, place; stop and idle ticks through
// load only; a tick that snaps through load, square and check; a tick that eases
// goes through those, then waits for the ease unit (a reciprocal multiply for the
// window divide and two multiplies), then the per-lane step multiply and advance.
// The next command is accepted the cycle after a result is loaded.
// The result sits in an output register; the next command is accepted
// while it waits, and that command's result holds until out_stall drops.
// Configuration (max offsets, overscroll) is written through cfg_we, cfg_addr and
// cfg_wdata, by the user only while no command is in flight; the block does not enforce it.
// Synchronous reset clears position, goal, velocity, animation and config.
module smooth_scroll_position_engine_core import ssp_pkg::*; #(
  parameter int SNAP_DISTANCE_Q8 = SnapDistanceDef,
  parameter int RUBBER_BAND_Q8   = RubberBandDef,
  parameter int EASE_WINDOW_MS   = EaseWindowDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_addr,
  input  logic [MaxW-1:0]        cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             in_func,
  input  logic signed [PosW-1:0] in_arg_x,
  input  logic signed [PosW-1:0] in_arg_y,
  input  logic [TimeW-1:0]       in_time_ms,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [PosW-1:0] out_pos_x,
  output logic signed [PosW-1:0] out_pos_y,
  output logic signed [PosW-1:0] out_vel_x,
  output logic signed [PosW-1:0] out_vel_y,
  output logic                   out_animating,
  output logic                   out_notify
);

  localparam logic [SqW:0] SnapSq =
    (SqW+1)'(longint'(SNAP_DISTANCE_Q8) * longint'(SNAP_DISTANCE_Q8));

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_CLAMP, S_PLACE, S_SQUARE, S_CHECK, S_WAIT, S_PROD, S_ADV, S_OUT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [2:0]             func_r;
  logic signed [PosW-1:0] arg_x_r, arg_y_r;
  logic [TimeW-1:0]       time_r;
  logic [MaxW-1:0]        max_h_r, max_v_r;
  logic                   ovs_r;
  logic                   moving_r, moving_nxt, notify_r, notify_nxt;
  logic                   ease_start;
  lane_ctl_t              lane_ctl;
  logic [EaseW-1:0]       ease;
  logic                   ease_done;
  logic signed [PosW-1:0] cur_x, cur_y, speed_x, speed_y;
  logic [SqW-1:0]         sq_x, sq_y;
  logic [SqW:0]           sq_sum;
  logic                   out_valid_r, out_load;
  logic signed [PosW-1:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r;
  logic                   anim_r, note_r;

  assign sq_sum   = {1'b0, sq_x} + {1'b0, sq_y};
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    moving_nxt      = moving_r;
    notify_nxt      = notify_r;
    lane_ctl.op     = LOP_NONE;
    lane_ctl.ovs_en = ovs_r;
    ease_start      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          notify_nxt = 1'b0;
          state_nxt  = S_LOAD;
        end
      end
      S_LOAD: begin
        state_nxt = S_OUT;
        case (func_r)
          FN_SET_POS: begin
            lane_ctl.op = LOP_LOAD_ARG;
            state_nxt   = S_PLACE;
          end
          FN_SCROLL_TO: begin
            lane_ctl.op = LOP_LOAD_ARG;
            state_nxt   = S_CLAMP;
          end
          FN_SCROLL_BY: begin
            lane_ctl.op = LOP_LOAD_SUM;
            state_nxt   = S_PLACE;
          end
          FN_TICK: begin
            if (moving_r) begin
              lane_ctl.op = LOP_DIFF;
              ease_start  = 1'b1;
              state_nxt   = S_SQUARE;
            end
          end
          FN_STOP: begin
            lane_ctl.op = LOP_STOP;
            moving_nxt  = 1'b0;
          end
          default: begin
          end
        endcase
      end
      S_CLAMP: begin
        lane_ctl.op = LOP_CLAMP_GOAL;
        if (time_r == '0) begin
          state_nxt = S_PLACE;
        end else begin
          moving_nxt = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_PLACE: begin
        lane_ctl.op = LOP_PLACE;
        moving_nxt  = 1'b0;
        notify_nxt  = 1'b1;
        state_nxt   = S_OUT;
      end
      S_SQUARE: begin
        lane_ctl.op = LOP_SQUARE;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        if (sq_sum < SnapSq) begin
          lane_ctl.op = LOP_SNAP;
          moving_nxt  = 1'b0;
          notify_nxt  = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (ease_done) begin
          state_nxt = S_PROD;
        end
      end
      S_PROD: begin
        lane_ctl.op = LOP_PROD;
        state_nxt   = S_ADV;
      end
      S_ADV: begin
        lane_ctl.op = LOP_ADVANCE;
        notify_nxt  = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      moving_r    <= 1'b0;
      notify_r    <= 1'b0;
      out_valid_r <= 1'b0;
      max_h_r     <= '0;
      max_v_r     <= '0;
      ovs_r       <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      moving_r <= moving_nxt;
      notify_r <= notify_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_MAX_H: max_h_r <= cfg_wdata;
          CFG_MAX_V: max_v_r <= cfg_wdata;
          CFG_OVS:   ovs_r   <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      func_r  <= in_func;
      arg_x_r <= in_arg_x;
      arg_y_r <= in_arg_y;
      time_r  <= in_time_ms;
    end
    if (out_load) begin
      pos_x_r <= cur_x;
      pos_y_r <= cur_y;
      vel_x_r <= speed_x;
      vel_y_r <= speed_y;
      anim_r  <= moving_r;
      note_r  <= notify_r;
    end
  end

  ssp_lane #(.RUBBER_BAND_Q8(RUBBER_BAND_Q8)) u_lane_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (lane_ctl),
    .arg     (arg_x_r),
    .max_pos (max_h_r),
    .ease    (ease),
    .cur     (cur_x),
    .speed   (speed_x),
    .sq      (sq_x)
  );

  ssp_lane #(.RUBBER_BAND_Q8(RUBBER_BAND_Q8)) u_lane_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (lane_ctl),
    .arg     (arg_y_r),
    .max_pos (max_v_r),
    .ease    (ease),
    .cur     (cur_y),
    .speed   (speed_y),
    .sq      (sq_y)
  );

  ssp_ease #(.EASE_WINDOW_MS(EASE_WINDOW_MS)) u_ease (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ease_start),
    .dt    (time_r),
    .ease  (ease),
    .done  (ease_done)
  );

  assign out_valid     = out_valid_r;
  assign out_pos_x     = pos_x_r;
  assign out_pos_y     = pos_y_r;
  assign out_vel_x     = vel_x_r;
  assign out_vel_y     = vel_y_r;
  assign out_animating = anim_r;
  assign out_notify    = note_r;

endmodule

[rtl/ssp_lane.sv]
// One axis lane: position, goal and speed of one axis with clamp and easing step.
// Depends on ssp_pkg.
module ssp_lane import ssp_pkg::*; #(
  parameter int RUBBER_BAND_Q8 = RubberBandDef
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lane_ctl_t               ctl,
  input  logic signed [PosW-1:0]  arg,
  input  logic        [MaxW-1:0]  max_pos,
  input  logic        [EaseW-1:0] ease,
  output logic signed [PosW-1:0]  cur,
  output logic signed [PosW-1:0]  speed,
  output logic        [SqW-1:0]   sq
);

  localparam logic signed [9:0] RbS = 10'(RUBBER_BAND_Q8);

  logic signed [PosW-1:0] cur_r, cur_nxt, goal_r, goal_nxt, speed_r, speed_nxt;
  logic signed [PosW-1:0] tmp_r, tmp_nxt;
  logic signed [PosW:0]   diff_r;
  logic        [SqW-1:0]  sq_r;
  logic signed [42:0]     prod_r;

  logic signed [PosW-1:0] clamped, base, adv_pos;
  logic signed [PosW:0]   excess;
  logic signed [34:0]     rb_prod;
  logic signed [27:0]     rb_sum, sum_wide, adv_wide, spd_wide;
  logic signed [49:0]     sq_full;
  logic                   below, above;

  function automatic logic signed [PosW-1:0] sat24(input logic signed [27:0] v);
    logic signed [27:0] hi, lo;
    hi = 28'sd8388607;
    lo = -28'sd8388608;
    if (v > hi) begin
      sat24 = hi[PosW-1:0];
    end else if (v < lo) begin
      sat24 = lo[PosW-1:0];
    end else begin
      sat24 = v[PosW-1:0];
    end
  endfunction

  always_comb begin
    below   = tmp_r < 0;
    above   = tmp_r > $signed({1'b0, max_pos});
    base    = below ? '0 : $signed({1'b0, max_pos});
    excess  = {tmp_r[PosW-1], tmp_r} - {base[PosW-1], base};
    rb_prod = excess * RbS;
    rb_sum  = 28'(base) + 28'(rb_prod >>> 8);
    if (!below && !above) begin
      clamped = tmp_r;
    end else if (ctl.ovs_en) begin
      clamped = sat24(rb_sum);
    end else begin
      clamped = base;
    end
  end

  always_comb begin
    sum_wide = 28'(cur_r) + 28'(arg);
    sq_full  = diff_r * diff_r;
    adv_wide = 28'(cur_r) + 28'(prod_r >>> 16);
    adv_pos  = sat24(adv_wide);
    spd_wide = 28'(adv_pos) - 28'(cur_r);
  end

  always_comb begin
    cur_nxt   = cur_r;
    goal_nxt  = goal_r;
    speed_nxt = speed_r;
    tmp_nxt   = tmp_r;
    case (ctl.op)
      LOP_LOAD_ARG: begin
        tmp_nxt = arg;
      end
      LOP_LOAD_SUM: begin
        tmp_nxt = sat24(sum_wide);
      end
      LOP_CLAMP_GOAL: begin
        goal_nxt = clamped;
        tmp_nxt  = clamped;
      end
      LOP_PLACE: begin
        cur_nxt   = clamped;
        goal_nxt  = clamped;
        speed_nxt = '0;
      end
      LOP_STOP: begin
        speed_nxt = '0;
      end
      LOP_SNAP: begin
        cur_nxt   = goal_r;
        speed_nxt = '0;
      end
      LOP_ADVANCE: begin
        cur_nxt   = adv_pos;
        speed_nxt = sat24(spd_wide);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      goal_r  <= '0;
      speed_r <= '0;
    end else begin
      cur_r   <= cur_nxt;
      goal_r  <= goal_nxt;
      speed_r <= speed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tmp_r <= tmp_nxt;
    if (ctl.op == LOP_DIFF) begin
      diff_r <= {goal_r[PosW-1], goal_r} - {cur_r[PosW-1], cur_r};
    end
    if (ctl.op == LOP_SQUARE) begin
      sq_r <= sq_full[SqW-1:0];
    end
    if (ctl.op == LOP_PROD) begin
      prod_r <= diff_r * $signed({1'b0, ease});
    end
  end

  assign cur   = cur_r;
  assign speed = speed_r;
  assign sq    = sq_r;

endmodule

[rtl/ssp_ease.sv]
// Ease factor unit: smoothstep of min(1, dt / window) in Q1.16.
// Reciprocal multiply for the window divide, then two registered multiplies. Depends on ssp_pkg.
module ssp_ease import ssp_pkg::*; #(
  parameter int EASE_WINDOW_MS = EaseWindowDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [TimeW-1:0] dt,
  output logic [EaseW-1:0] ease,
  output logic             done
);

  localparam logic [TimeW-1:0] WinQ   = TimeW'(EASE_WINDOW_MS);
  localparam int               ShL    = $clog2(EASE_WINDOW_MS);
  localparam logic [33:0]      RecipQ =
    34'(((longint'(1) <<< (32 + ShL)) + longint'(EASE_WINDOW_MS) - longint'(1)) /
        longint'(EASE_WINDOW_MS));

  typedef enum logic [1:0] {E_IDLE, E_SQ, E_MUL} ease_state_t;

  ease_state_t      state_r;
  logic [EaseW-1:0] q_r;
  logic [32:0]      tt_r;
  logic [EaseW-1:0] ease_r;
  logic             done_r;
  logic [TimeW-1:0] d_lim;
  logic [49:0]      recip_prod;
  logic [49:0]      q_full;
  logic [17:0]      lin;
  logic [33:0]      tt_full;
  logic [50:0]      full;

  always_comb begin
    d_lim      = (dt < WinQ) ? dt : WinQ;
    recip_prod = 50'(d_lim) * 50'(RecipQ);
    q_full     = recip_prod >> (16 + ShL);
    tt_full    = q_r * q_r;
    lin        = 18'd196608 - {q_r, 1'b0};
    full       = tt_r * lin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      done_r  <= 1'b0;
    end else if (start) begin
      done_r  <= 1'b0;
      q_r     <= q_full[EaseW-1:0];
      state_r <= E_SQ;
    end else begin
      case (state_r)
        E_SQ: begin
          tt_r    <= tt_full[32:0];
          state_r <= E_MUL;
        end
        E_MUL: begin
          ease_r  <= full[48:32];
          done_r  <= 1'b1;
          state_r <= E_IDLE;
        end
        default: begin
        end
      endcase
    end
  end

  assign ease = ease_r;
  assign done = done_r;

endmodule
